@@ rtl/core/mjdg_pkg.sv @@
`default_nettype none
package mjdg_pkg;
   localparam int MaxItems = 1024;
   localparam int AddrW = $clog2(MaxItems);
   localparam int CntW = AddrW + 1;
   localparam int CostW = 20;
   localparam int LimitW = 32;
   localparam int KeyW = 33;
   localparam int TotalW = 34;
   localparam int DoneW = 11;

   typedef struct packed {
      logic [CostW-1:0]  cost;
      logic [LimitW-1:0] limit;
   } job_type;

   function automatic logic [KeyW-1:0] job_key(input job_type j);
      job_key = KeyW'(j.cost) + KeyW'(j.limit);
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/mjdg_sorter.sv @@
`default_nettype none
// Bottom-up merge sort between two job memories, one merged word written per compare step.
module mjdg_sorter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  ld_we,
   input  wire logic [mjdg_pkg::AddrW-1:0] ld_addr,
   input  wire mjdg_pkg::job_type     ld_job,
   input  wire logic                  start,
   input  wire logic [mjdg_pkg::CntW-1:0] count,
   output logic                       done,
   input  wire logic [mjdg_pkg::AddrW-1:0] rd_addr,
   output mjdg_pkg::job_type          rd_job
);
   import mjdg_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RDA, S_RDB, S_CMP, S_DONE} st_type;

   job_type mem_a [MaxItems];
   job_type mem_b [MaxItems];

   st_type st_ff;
   logic src_ff; // 0: data in mem_a
   logic [CntW:0] width_ff, lo_ff, mid_ff, hi_ff, a_ff, b_ff, k_ff;
   job_type ja_ff, jb, rda_ff, rdb_ff;
   logic [AddrW-1:0] ra_in;
   logic [CntW:0] n;
   logic [CntW:0] mid_in, hi_in;
   logic take_b;
   logic merge_we;

   assign n = (CntW+1)'(count);
   assign mid_in = (lo_ff + width_ff < n) ? lo_ff + width_ff : n;
   assign hi_in = (lo_ff + (width_ff << 1) < n) ? lo_ff + (width_ff << 1) : n;
   // word at b_ff is in the read register during S_CMP
   assign jb = src_ff ? rdb_ff : rda_ff;
   assign take_b = (a_ff >= mid_ff) ||
                   ((b_ff < hi_ff) && (job_key(jb) < job_key(ja_ff)));
   assign merge_we = (st_ff == S_CMP) && (k_ff != hi_ff);

   always_comb begin
      ra_in = rd_addr;
      if (st_ff == S_RDA) ra_in = a_ff[AddrW-1:0];
      else if (st_ff == S_RDB) ra_in = b_ff[AddrW-1:0];
   end

   // final data lands in mem_a or mem_b; read side picks by src_ff
   always_ff @(posedge clock) begin
      if (ld_we) mem_a[ld_addr] <= ld_job;
      else if (merge_we && src_ff) mem_a[k_ff[AddrW-1:0]] <= take_b ? jb : ja_ff;
      if (merge_we && !src_ff) mem_b[k_ff[AddrW-1:0]] <= take_b ? jb : ja_ff;
      rda_ff <= mem_a[ra_in];
      rdb_ff <= mem_b[ra_in];
   end

   assign rd_job = src_ff ? rdb_ff : rda_ff;
   assign done = (st_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         src_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            S_IDLE: if (start) begin
               src_ff <= 1'b0;
               width_ff <= (CntW+1)'(1);
               lo_ff <= '0;
               st_ff <= S_SETUP;
            end
            S_SETUP: begin
               if (width_ff >= n) st_ff <= S_DONE;
               else if (lo_ff >= n) begin
                  width_ff <= width_ff << 1;
                  lo_ff <= '0;
                  src_ff <= ~src_ff;
               end else begin
                  mid_ff <= mid_in;
                  hi_ff <= hi_in;
                  a_ff <= lo_ff;
                  b_ff <= mid_in;
                  k_ff <= lo_ff;
                  st_ff <= S_RDA;
               end
            end
            S_RDA: st_ff <= S_RDB;
            S_RDB: begin
               ja_ff <= src_ff ? rdb_ff : rda_ff;
               st_ff <= S_CMP;
            end
            S_CMP: begin
               if (st_ff == S_CMP && k_ff == hi_ff) begin
                  lo_ff <= hi_ff;
                  st_ff <= S_SETUP;
               end else begin
                  if (take_b) b_ff <= b_ff + 1'b1;
                  else a_ff <= a_ff + 1'b1;
                  k_ff <= k_ff + 1'b1;
                  st_ff <= S_RDA;
               end
            end
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CMP |-> k_ff <= hi_ff) else $error("merge index past run");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
   a_ab: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CMP |-> a_ff <= mid_ff && b_ff <= hi_ff) else $error("merge ptr");
`endif
endmodule
`default_nettype wire

@@ rtl/core/mjdg_heap.sv @@
`default_nettype none
// Max-heap of accepted costs in one memory; replace-top sifts down one level per read and compare pass.
module mjdg_heap (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire logic                      repl,
   input  wire logic [mjdg_pkg::CostW-1:0] val,
   input  wire logic                      clear,
   output logic                           busy,
   output logic [mjdg_pkg::CostW-1:0]      top,
   output logic [mjdg_pkg::CntW-1:0]       size
);
   import mjdg_pkg::*;

   typedef enum logic [2:0] {H_IDLE, H_UP_RD, H_UP_CMP, H_DN_RDL, H_DN_RDR, H_DN_CMP} st_type;

   logic [CostW-1:0] mem [MaxItems];
   logic [CostW-1:0] rd_ff, top_ff, lv_ff, cur_ff;
   logic [AddrW-1:0] ra, wa;
   logic [CostW-1:0] wd;
   logic we;
   st_type st_ff;
   logic [CntW-1:0] size_ff;
   logic [CntW:0] pos_ff;
   logic [CntW:0] l_w, r_w, par_w;

   assign l_w = (pos_ff << 1) + 1'b1;
   assign r_w = l_w + 1'b1;
   assign par_w = (pos_ff - 1'b1) >> 1;
   assign busy = (st_ff != H_IDLE);
   assign top = top_ff;
   assign size = size_ff;

   always_comb begin
      ra = '0; we = 1'b0; wa = '0; wd = cur_ff;
      unique case (st_ff)
         H_UP_RD: ra = par_w[AddrW-1:0];
         H_DN_RDL: ra = l_w[AddrW-1:0];
         H_DN_RDR: ra = r_w[AddrW-1:0];
         H_IDLE: begin
            if (push && size_ff < CntW'(MaxItems)) begin
               we = 1'b1; wa = size_ff[AddrW-1:0]; wd = val;
            end else if (repl) begin
               we = 1'b1; wa = '0; wd = val;
            end
         end
         H_UP_CMP: if (pos_ff != 0 && rd_ff < cur_ff) begin
            we = 1'b1; wa = pos_ff[AddrW-1:0]; wd = rd_ff;
         end else begin
            we = 1'b1; wa = pos_ff[AddrW-1:0]; wd = cur_ff;
         end
         H_DN_CMP: begin
            we = 1'b1; wa = pos_ff[AddrW-1:0]; wd = cur_ff;
            if (l_w < (CntW+1)'(size_ff) && lv_ff > cur_ff &&
                !(r_w < (CntW+1)'(size_ff) && rd_ff > lv_ff)) wd = lv_ff;
            else if (r_w < (CntW+1)'(size_ff) && rd_ff > cur_ff &&
                     !(lv_ff > rd_ff && l_w < (CntW+1)'(size_ff))) wd = rd_ff;
            else if (r_w < (CntW+1)'(size_ff) && rd_ff > cur_ff) wd = rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   logic l_big, r_big;
   assign l_big = l_w < (CntW+1)'(size_ff) && lv_ff > cur_ff;
   assign r_big = r_w < (CntW+1)'(size_ff) && rd_ff > cur_ff && !(l_big && lv_ff >= rd_ff);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         st_ff <= H_IDLE;
         size_ff <= '0;
         top_ff <= '0;
      end else begin
         unique case (st_ff)
            H_IDLE: begin
               if (push && size_ff < CntW'(MaxItems)) begin
                  pos_ff <= (CntW+1)'(size_ff);
                  cur_ff <= val;
                  size_ff <= size_ff + 1'b1;
                  if (size_ff == 0) top_ff <= val;
                  else st_ff <= H_UP_RD;
               end else if (repl) begin
                  pos_ff <= '0;
                  cur_ff <= val;
                  st_ff <= H_DN_RDL;
               end
            end
            H_UP_RD: st_ff <= H_UP_CMP;
            H_UP_CMP: begin
               if (pos_ff != 0 && rd_ff < cur_ff) begin
                  pos_ff <= par_w;
                  if (par_w == 0) begin
                     top_ff <= cur_ff;
                     st_ff <= H_UP_CMP;
                  end else st_ff <= H_UP_RD;
               end else begin
                  if (pos_ff == 0) top_ff <= cur_ff;
                  st_ff <= H_IDLE;
               end
            end
            H_DN_RDL: st_ff <= H_DN_RDR;
            H_DN_RDR: begin
               lv_ff <= rd_ff;
               st_ff <= H_DN_CMP;
            end
            H_DN_CMP: begin
               if (pos_ff == 0) top_ff <= (l_big || r_big) ? (r_big ? rd_ff : lv_ff) : cur_ff;
               if (r_big) begin
                  pos_ff <= r_w; st_ff <= H_DN_RDL;
               end else if (l_big) begin
                  pos_ff <= l_w; st_ff <= H_DN_RDL;
               end else st_ff <= H_IDLE;
            end
            default: st_ff <= H_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_size: assert property (@(posedge clock) disable iff (reset)
      size_ff <= CntW'(MaxItems)) else $error("heap size");
   a_busy_in: assert property (@(posedge clock) disable iff (reset)
      busy |-> !push && !repl) else $error("heap op while busy");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      busy |-> pos_ff < (CntW+1)'(size_ff)) else $error("heap pos");
`endif
endmodule
`default_nettype wire

@@ rtl/core/max_jobs_by_deadline_greedy_top.sv @@
`default_nettype none
// Max on-time job count (exchange greedy).
// req_ channel: one job word per accepted cycle (req_job_cost, req_job_limit,
// req_last_job). Jobs past 1024 are dropped and flagged.
// On the last job the block sorts the stored jobs by cost + limit with a
// bottom-up merge sort over two job memories (ceil(log2(n)) passes), then
// scans them in order against a max-heap of accepted costs, with a heap
// sift on each accept and on each replace.
// req_stall is high from the last job until the result word is taken.
// rsp_ channel: one word (rsp_jobs_done, rsp_overflowed) per set, held while
// rsp_stall is high. Delivery clears the count, overflow flag, total and heap.
// Reset is synchronous; it empties the job store and the heap and drops any
// pending result. No clearing pass is needed.
module max_jobs_by_deadline_greedy_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [19:0] req_job_cost,
   input  wire logic [31:0] req_job_limit,
   input  wire logic        req_last_job,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [10:0]      rsp_jobs_done,
   output logic             rsp_overflowed
);
   import mjdg_pkg::*;

   typedef enum logic [2:0] {T_LOAD, T_SORT, T_RD, T_WAIT, T_EVAL, T_HEAP, T_OUT} st_type;

   st_type st_ff;
   logic [CntW-1:0] cnt_ff, idx_ff;
   logic ovf_ff;
   logic [TotalW-1:0] total_ff;
   logic acc;
   logic sort_start, sort_done;
   job_type rd_job, job;
   logic h_push, h_repl, h_busy;
   logic [CostW-1:0] h_top;
   logic [CntW-1:0] h_size;

   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != T_LOAD);
   assign job.cost = req_job_cost;
   assign job.limit = req_job_limit;
   assign sort_start = (st_ff == T_SORT);

   mjdg_sorter u_sort (
      .clock, .reset,
      .ld_we(acc && cnt_ff < CntW'(MaxItems)),
      .ld_addr(cnt_ff[AddrW-1:0]), .ld_job(job),
      .start(sort_start), .count(cnt_ff), .done(sort_done),
      .rd_addr(idx_ff[AddrW-1:0]), .rd_job(rd_job)
   );

   logic in_time, cheaper;
   assign in_time = total_ff <= TotalW'(rd_job.limit);
   assign cheaper = h_size != 0 && rd_job.cost < h_top;
   assign h_push = (st_ff == T_EVAL) && in_time;
   assign h_repl = (st_ff == T_EVAL) && !in_time && cheaper;

   mjdg_heap u_heap (
      .clock, .reset, .push(h_push), .repl(h_repl), .val(rd_job.cost),
      .clear(st_ff == T_OUT && !rsp_stall), .busy(h_busy), .top(h_top), .size(h_size)
   );

   logic sort_go_ff;
   assign rsp_valid = (st_ff == T_OUT);
   assign rsp_jobs_done = DoneW'(h_size);
   assign rsp_overflowed = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= T_LOAD;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         total_ff <= '0;
         idx_ff <= '0;
         sort_go_ff <= 1'b0;
      end else begin
         unique case (st_ff)
            T_LOAD: if (acc) begin
               if (cnt_ff < CntW'(MaxItems)) cnt_ff <= cnt_ff + 1'b1;
               else ovf_ff <= 1'b1;
               if (req_last_job) begin
                  st_ff <= T_SORT;
                  sort_go_ff <= 1'b0;
               end
            end
            T_SORT: begin
               sort_go_ff <= 1'b1;
               if (sort_go_ff && sort_done) begin
                  idx_ff <= '0;
                  st_ff <= T_RD;
               end
            end
            T_RD: st_ff <= (idx_ff == cnt_ff) ? T_OUT : T_WAIT;
            T_WAIT: st_ff <= T_EVAL;
            T_EVAL: begin
               if (in_time) total_ff <= total_ff + TotalW'(rd_job.cost);
               else if (cheaper) total_ff <= total_ff - TotalW'(h_top) + TotalW'(rd_job.cost);
               idx_ff <= idx_ff + 1'b1;
               st_ff <= T_HEAP;
            end
            T_HEAP: if (!h_busy) st_ff <= T_RD;
            T_OUT: if (!rsp_stall) begin
               st_ff <= T_LOAD;
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
               total_ff <= '0;
            end
            default: st_ff <= T_LOAD;
         endcase
      end
   end

`ifndef SYNTH
   a_idx: assert property (@(posedge clock) disable iff (reset)
      st_ff == T_EVAL |-> idx_ff < cnt_ff) else $error("scan past end");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxItems)) else $error("count");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_jobs_done)) else $error("rsp");
`endif
endmodule
`default_nettype wire
